[rtl/snmac_pkg.sv]
// ---------------------------------------------------------------------------
// snmac_pkg: shared types and constants of the sparse negacyclic MAC core
// Opcodes, size limits and digit constants.
// ---------------------------------------------------------------------------
`default_nettype none
package snmac_pkg;
  localparam int MAX_DEGREE = 1024;
  localparam int MAX_DIGITS = 4;
  localparam int MAX_TERMS  = 4095;
  localparam int DIGIT_BITS = 52;
  localparam logic [63:0] DIGIT_MASK = 64'h000F_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    OP_LOAD_A   = 3'd0,
    OP_LOAD_ACC = 3'd1,
    OP_APPLY    = 3'd2,
    OP_NORM     = 3'd3,
    OP_READ     = 3'd4
  } op_t;

  localparam logic CFG_DIGIT_CNT = 1'b0;
  localparam logic CFG_RING_LOG2 = 1'b1;
endpackage
`default_nettype wire

[rtl/sparse_negacyclic_mac_core.sv]
// ---------------------------------------------------------------------------
// sparse_negacyclic_mac_core: sparse multiply-accumulate mod X^N+1
// Channel   | dir | contents
// in_       | in  | tdata: op, coef_index, digit_index, digit_value,
//           |     |        term_shift, term_sign
// out_      | out | tdata: read_value, term_overflow
// cfg_      | in  | index 0 digit count, index 1 ring_size_log2
// Loads, unused opcodes and a rejected apply: result valid in the cycle after
// the input transfer. Read: S_FETCH waits for the registered RAM read, then the result is registered.
// Apply and normalize: a read state and a write-back state per digit, for every
// digit of every coefficient, on the single port of each RAM.
// in_tready is high in idle while the result register is empty or drains in
// the same cycle. Reset (rst_n, synchronous) clears control, the term count
// and the registers (4 digits, log2 N 10); RAM contents are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none
module sparse_negacyclic_mac_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // op[2:0], coef_index[12:3], digit_index[14:13], digit_value[78:15],
  // term_shift[88:79], term_sign[89], zero pad
  input  wire logic [95:0]  in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // read_value[63:0], term_overflow[64], zero pad
  output logic [71:0]       out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_index,
  input  wire logic [3:0]   cfg_data
);
  localparam int DEG_W = $clog2(snmac_pkg::MAX_DEGREE);
  localparam int DIG_W = $clog2(snmac_pkg::MAX_DIGITS);
  localparam int ADR_W = DEG_W + DIG_W;
  localparam int DEPTH = snmac_pkg::MAX_DEGREE * snmac_pkg::MAX_DIGITS;

  typedef enum logic [1:0] {
    S_IDLE, S_FETCH, S_RD, S_WR
  } state_t;

  // input fields
  logic [2:0]       f_op;
  logic [DEG_W-1:0] f_coef, f_shift;
  logic [DIG_W-1:0] f_dig;
  logic [63:0]      f_val;
  logic             f_sign;
  assign f_op    = in_tdata[2:0];
  assign f_coef  = in_tdata[12:3];
  assign f_dig   = in_tdata[14:13];
  assign f_val   = in_tdata[78:15];
  assign f_shift = in_tdata[88:79];
  assign f_sign  = in_tdata[89];

  // registers
  state_t           st_r, st_nxt;
  logic [2:0]       op_r, op_nxt;
  logic [DEG_W-1:0] j_r, j_nxt;
  logic [DEG_W-1:0] t_r, t_nxt;
  logic             sign_r, sign_nxt;
  logic [DIG_W-1:0] k_r, k_nxt;
  logic [11:0]      carry_r, carry_nxt;
  logic [12:0]      terms_r, terms_nxt;
  logic [63:0]      rv_r, rv_nxt;
  logic             ovf_r, ovf_nxt;
  logic             pos_ok_r, pos_ok_nxt;
  logic             ov_r, ov_nxt;
  logic [2:0]       nd_r;
  logic [3:0]       rl_r;

  // effective digit count and degree
  logic [2:0]       d_eff;
  logic [3:0]       r_eff;
  logic [DEG_W:0]   n_eff;
  logic [DEG_W-1:0] mask;
  logic [DIG_W-1:0] last_k;
  always_comb begin
    d_eff = nd_r;
    if (nd_r == 3'd0) d_eff = 3'd1;
    if (nd_r > 3'(snmac_pkg::MAX_DIGITS)) d_eff = 3'(snmac_pkg::MAX_DIGITS);
    r_eff = rl_r;
    if (rl_r < 4'd3) r_eff = 4'd3;
    if (rl_r > 4'(DEG_W)) r_eff = 4'(DEG_W);
    n_eff = (DEG_W+1)'(1) << r_eff;
  end
  assign mask   = DEG_W'(n_eff - (DEG_W+1)'(1));
  assign last_k = DIG_W'(d_eff - 3'd1);

  // handshakes
  logic in_acc, in_pos_ok;
  assign in_tready  = (st_r == S_IDLE) && (!ov_r || out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign in_pos_ok  = ({1'b0, f_coef} < n_eff) && ({1'b0, f_dig} < d_eff);
  assign cfg_ready  = (st_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = {7'b0, ovf_r, rv_r};

  // source coefficient and sign of the current sweep position
  logic [DEG_W:0]   tj;
  logic [DEG_W-1:0] pos;
  logic             neg;
  assign tj  = {1'b0, t_r} + {1'b0, j_r};
  assign pos = tj[DEG_W-1:0] & mask;
  assign neg = (tj >= n_eff) ^ sign_r;

  // RAMs
  logic             a_we, c_we;
  logic [ADR_W-1:0] a_addr, c_addr;
  logic [63:0]      c_wd, c_rd;
  logic [51:0]      a_rd;

  snmac_ram #(.WIDTH(52), .DEPTH(DEPTH)) u_a (
    .clk(clk), .we(a_we), .addr(a_addr), .wdata(f_val[51:0]), .rdata(a_rd));
  snmac_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_c (
    .clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wd), .rdata(c_rd));

  // digit datapath: negation borrows via carry_r[0], normalize via carry_r
  logic [52:0] inv_sum;
  logic [51:0] add_dig;
  logic [63:0] acc_sum, norm_sum, wb_val;
  assign inv_sum  = {1'b0, ~a_rd} + {52'b0, carry_r[0]};
  assign add_dig  = neg ? inv_sum[51:0] : a_rd;
  assign acc_sum  = c_rd + {12'b0, add_dig};
  assign norm_sum = c_rd + {52'b0, carry_r};
  assign wb_val   = (op_r == snmac_pkg::OP_APPLY) ? acc_sum
                                                  : (norm_sum & snmac_pkg::DIGIT_MASK);

  // RAM access
  always_comb begin
    a_we   = 1'b0;
    c_we   = 1'b0;
    a_addr = {f_coef, f_dig};
    c_addr = {f_coef, f_dig};
    c_wd   = f_val;
    unique case (st_r)
      S_IDLE: begin
        a_we = in_acc && in_pos_ok && (f_op == snmac_pkg::OP_LOAD_A);
        c_we = in_acc && in_pos_ok && (f_op == snmac_pkg::OP_LOAD_ACC);
      end
      S_RD: begin
        a_addr = {pos, k_r};
        c_addr = {j_r, k_r};
      end
      S_WR: begin
        c_addr = {j_r, k_r};
        c_we   = 1'b1;
        c_wd   = wb_val;
      end
      default: ;
    endcase
  end

  // sequencing: sweep digits from least to most significant per coefficient
  always_comb begin
    st_nxt     = st_r;
    op_nxt     = op_r;
    j_nxt      = j_r;
    t_nxt      = t_r;
    sign_nxt   = sign_r;
    k_nxt      = k_r;
    carry_nxt  = carry_r;
    terms_nxt  = terms_r;
    rv_nxt     = rv_r;
    ovf_nxt    = ovf_r;
    pos_ok_nxt = pos_ok_r;
    ov_nxt     = ov_r;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt     = f_op;
          rv_nxt     = '0;
          ovf_nxt    = 1'b0;
          j_nxt      = '0;
          k_nxt      = last_k;
          t_nxt      = f_shift & mask;
          sign_nxt   = f_sign;
          pos_ok_nxt = in_pos_ok;
          unique case (f_op)
            snmac_pkg::OP_APPLY: begin
              if (terms_r >= 13'(snmac_pkg::MAX_TERMS)) begin
                ovf_nxt = 1'b1;
                ov_nxt  = 1'b1;
              end else begin
                terms_nxt = terms_r + 13'd1;
                carry_nxt = 12'd1;
                st_nxt    = S_RD;
              end
            end
            snmac_pkg::OP_NORM: begin
              terms_nxt = '0;
              carry_nxt = 12'd0;
              st_nxt    = S_RD;
            end
            snmac_pkg::OP_READ: st_nxt = S_FETCH;
            default: ov_nxt = 1'b1;
          endcase
        end
      end
      S_FETCH: begin
        if (pos_ok_r) rv_nxt = c_rd;
        ov_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      S_RD: st_nxt = S_WR;
      S_WR: begin
        carry_nxt = (op_r == snmac_pkg::OP_APPLY) ? {11'b0, inv_sum[52]}
                                                  : norm_sum[63:snmac_pkg::DIGIT_BITS];
        if (k_r == '0) begin
          k_nxt     = last_k;
          carry_nxt = (op_r == snmac_pkg::OP_APPLY) ? 12'd1 : 12'd0;
          if (j_r == mask) begin
            ov_nxt = 1'b1;
            st_nxt = S_IDLE;
          end else begin
            j_nxt  = j_r + DEG_W'(1);
            st_nxt = S_RD;
          end
        end else begin
          k_nxt  = k_r - DIG_W'(1);
          st_nxt = S_RD;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // state, registered outputs and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      op_r     <= '0;
      j_r      <= '0;
      t_r      <= '0;
      sign_r   <= 1'b0;
      k_r      <= '0;
      carry_r  <= '0;
      terms_r  <= '0;
      rv_r     <= '0;
      ovf_r    <= 1'b0;
      pos_ok_r <= 1'b0;
      ov_r     <= 1'b0;
      nd_r     <= 3'd4;
      rl_r     <= 4'd10;
    end else begin
      st_r     <= st_nxt;
      op_r     <= op_nxt;
      j_r      <= j_nxt;
      t_r      <= t_nxt;
      sign_r   <= sign_nxt;
      k_r      <= k_nxt;
      carry_r  <= carry_nxt;
      terms_r  <= terms_nxt;
      rv_r     <= rv_nxt;
      ovf_r    <= ovf_nxt;
      pos_ok_r <= pos_ok_nxt;
      ov_r     <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == snmac_pkg::CFG_DIGIT_CNT) nd_r <= cfg_data[2:0];
        else rl_r <= cfg_data;
      end
    end
  end
endmodule
`default_nettype wire

[rtl/snmac_ram.sv]
// ---------------------------------------------------------------------------
// snmac_ram: generic single-port RAM
// One address and one read per cycle, with a write beside the read when we is high; read data registered.
// ---------------------------------------------------------------------------
`default_nettype none
module snmac_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write, registered read
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire
